### hdl/pfb_pkg.sv
// pfb_pkg: shared constants, command codes and sequencer states
// for the page frame buffer blitter; no dependencies
package pfb_pkg;
  localparam int COLUMNS = 128;
  localparam int PAGES = 8;
  localparam int IMAGE_BYTES = 1024;
  localparam int FRAME_BYTES = COLUMNS * PAGES;
  localparam int FA_W = $clog2(FRAME_BYTES);
  localparam int IA_W = $clog2(IMAGE_BYTES);
  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROWS = 8 * PAGES;
  localparam int ROW_W = $clog2(ROWS) + 1;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_DOT   = 3'd1,
    CMD_BOX   = 3'd2,
    CMD_IMAGE = 3'd3,
    CMD_LOAD  = 3'd4,
    CMD_READ  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_IMG_RD,
    ST_FR_RD,
    ST_FR_WR,
    ST_RD_WAIT,
    ST_OUT
  } state_t;
endpackage

### hdl/pfb_frame_ram.sv
// pfb_frame_ram: frame store, one write port and one registered read port
// depends on pfb_pkg
module pfb_frame_ram (
  input  logic                   clk,
  input  logic                   we,
  input  logic [pfb_pkg::FA_W-1:0] waddr,
  input  logic [7:0]             wdata,
  input  logic [pfb_pkg::FA_W-1:0] raddr,
  output logic [7:0]             rdata
);
  logic [7:0] mem [pfb_pkg::FRAME_BYTES];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hdl/pfb_image_ram.sv
// pfb_image_ram: image store, one write port and one registered read port
// depends on pfb_pkg
module pfb_image_ram (
  input  logic                   clk,
  input  logic                   we,
  input  logic [pfb_pkg::IA_W-1:0] waddr,
  input  logic [7:0]             wdata,
  input  logic [pfb_pkg::IA_W-1:0] raddr,
  output logic [7:0]             rdata
);
  logic [7:0] mem [pfb_pkg::IMAGE_BYTES];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hdl/page_framebuffer_blitter_core.sv
// page_framebuffer_blitter_core: top level, command sequencer walking
// one pixel per step; depends on pfb_pkg, pfb_frame_ram, pfb_image_ram
//
// Each command is one item. Load writes its image byte as it is accepted,
// read goes through a wait state and then an output state that holds while
// the result is stalled, and clear writes one frame byte per cycle. Dot,
// box and image are accepted, then walk the clipped box one pixel
// at a time: each pixel is an image byte fetch (image only), a frame byte read
// and a frame byte write through the single frame store port pair. After
// reset the frame store is cleared before the first item is taken. The block
// takes no new item until the current one is done.
module page_framebuffer_blitter_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_command,
  input  logic [6:0] in_pos_x,
  input  logic [5:0] in_pos_y,
  input  logic [7:0] in_width,
  input  logic [6:0] in_height,
  input  logic       in_inverted,
  input  logic       in_vertical,
  input  logic [9:0] in_src_base,
  input  logic [9:0] in_address,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data
);
  localparam int FA = pfb_pkg::FA_W;
  localparam int IA = pfb_pkg::IA_W;
  localparam int RW = pfb_pkg::ROW_W;

  pfb_pkg::state_t state_r, state_nxt;
  logic [FA-1:0] clr_r;
  logic [8:0]    col_r, xend_r, x_r;
  logic [RW-1:0] row_r, yend_r, y_r;
  logic [7:0]    w_r;
  logic          inv_r, vert_r, img_r, setv_r, oor_r;
  logic [IA-1:0] base_r;
  logic [FA-1:0] raddr_r;
  logic [7:0]    rd_r;
  logic          pix_val;

  logic          in_acc;
  logic          fr_we, im_we;
  logic [FA-1:0] fr_waddr, fr_raddr;
  logic [7:0]    fr_wdata, fr_rdata, im_rdata;
  logic [IA-1:0] im_raddr;
  logic [FA-1:0] pix_addr;
  logic [8:0]    rx, cx;
  logic [RW-1:0] ry;
  logic [7:0]    stride;
  logic [18:0]   ioff;
  logic [7:0]    bitm;
  logic [8:0]    xe;
  logic [RW:0]   ye;
  logic          empty;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != pfb_pkg::ST_IDLE);

  // clipped end bounds for the incoming item
  always_comb begin
    logic [7:0] wi;
    logic [6:0] hi;
    wi = (in_command == pfb_pkg::CMD_DOT) ? 8'd1 : in_width;
    hi = (in_command == pfb_pkg::CMD_DOT) ? 7'd1 : in_height;
    xe = 9'(in_pos_x) + 9'(wi);
    if (xe > 9'(pfb_pkg::COLUMNS)) xe = 9'(pfb_pkg::COLUMNS);
    ye = (RW+1)'(in_pos_y) + (RW+1)'(hi);
    if (ye > (RW+1)'(pfb_pkg::ROWS)) ye = (RW+1)'(pfb_pkg::ROWS);
    empty = (wi == 8'd0) || (hi == 7'd0) || (9'(in_pos_x) >= xe)
            || ((RW+1)'(in_pos_y) >= ye);
  end

  assign pix_addr = FA'(row_r[RW-1:3]) * FA'(pfb_pkg::COLUMNS) + FA'(col_r);
  assign rx = col_r - x_r;
  assign ry = row_r - y_r;
  assign cx = 9'(w_r);
  assign stride = 8'((9'(w_r) + 9'd7) >> 3);
  assign ioff = vert_r ? 19'(11'(ry >> 3) * cx) + 19'(rx)
                       : 19'(ry) * 19'(stride) + 19'(rx >> 3);
  assign im_raddr = base_r + IA'(ioff);
  assign bitm = 8'd1 << row_r[2:0];

  always_comb begin
    logic [2:0] sh;
    sh = vert_r ? ry[2:0] : 3'(3'd7 - rx[2:0]);
    pix_val = img_r ? (im_rdata[sh] ^ inv_r) : setv_r;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pfb_pkg::ST_IDLE: if (in_acc) begin
        case (in_command)
          pfb_pkg::CMD_CLEAR: state_nxt = pfb_pkg::ST_CLEAR;
          pfb_pkg::CMD_DOT, pfb_pkg::CMD_BOX:
            state_nxt = empty ? pfb_pkg::ST_IDLE : pfb_pkg::ST_FR_RD;
          pfb_pkg::CMD_IMAGE:
            state_nxt = empty ? pfb_pkg::ST_IDLE : pfb_pkg::ST_IMG_RD;
          pfb_pkg::CMD_READ: state_nxt = pfb_pkg::ST_RD_WAIT;
          default: state_nxt = pfb_pkg::ST_IDLE;
        endcase
      end
      pfb_pkg::ST_CLEAR:
        if (clr_r == FA'(pfb_pkg::FRAME_BYTES - 1)) state_nxt = pfb_pkg::ST_IDLE;
      pfb_pkg::ST_IMG_RD: state_nxt = pfb_pkg::ST_FR_RD;
      pfb_pkg::ST_FR_RD: state_nxt = pfb_pkg::ST_FR_WR;
      pfb_pkg::ST_FR_WR: begin
        if (col_r + 9'd1 < xend_r) state_nxt = img_r ? pfb_pkg::ST_IMG_RD
                                                     : pfb_pkg::ST_FR_RD;
        else if (row_r + 1'b1 < yend_r) state_nxt = img_r ? pfb_pkg::ST_IMG_RD
                                                          : pfb_pkg::ST_FR_RD;
        else state_nxt = pfb_pkg::ST_IDLE;
      end
      pfb_pkg::ST_RD_WAIT: state_nxt = pfb_pkg::ST_OUT;
      pfb_pkg::ST_OUT: if (!out_stall) state_nxt = pfb_pkg::ST_IDLE;
      default: state_nxt = pfb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    fr_we = 1'b0;
    fr_waddr = pix_addr;
    fr_wdata = pix_val ? (fr_rdata | bitm) : (fr_rdata & ~bitm);
    fr_raddr = pix_addr;
    im_we = 1'b0;
    case (state_r)
      pfb_pkg::ST_IDLE: begin
        fr_raddr = in_address[FA-1:0];
        im_we = in_acc && (in_command == pfb_pkg::CMD_LOAD);
      end
      pfb_pkg::ST_CLEAR: begin
        fr_we = 1'b1;
        fr_waddr = clr_r;
        fr_wdata = 8'h00;
      end
      pfb_pkg::ST_FR_WR: fr_we = 1'b1;
      pfb_pkg::ST_RD_WAIT, pfb_pkg::ST_OUT: fr_raddr = raddr_r;
      default: fr_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfb_pkg::ST_CLEAR;
      clr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == pfb_pkg::ST_CLEAR) clr_r <= clr_r + 1'b1;
      else clr_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == pfb_pkg::ST_IDLE && in_acc) begin
      col_r <= 9'(in_pos_x);
      x_r <= 9'(in_pos_x);
      row_r <= RW'(in_pos_y);
      y_r <= RW'(in_pos_y);
      xend_r <= xe;
      yend_r <= RW'(ye);
      w_r <= in_width;
      inv_r <= in_inverted;
      vert_r <= in_vertical;
      img_r <= (in_command == pfb_pkg::CMD_IMAGE);
      setv_r <= !in_inverted;
      base_r <= in_src_base[IA-1:0];
      raddr_r <= in_address[FA-1:0];
      oor_r <= (11'(in_address) >= 11'(pfb_pkg::FRAME_BYTES));
    end else if (state_r == pfb_pkg::ST_FR_WR) begin
      if (col_r + 9'd1 < xend_r) col_r <= col_r + 9'd1;
      else begin
        col_r <= x_r;
        row_r <= row_r + 1'b1;
      end
    end
    if (state_r == pfb_pkg::ST_RD_WAIT) rd_r <= oor_r ? 8'h00 : fr_rdata;
  end

  assign out_valid = (state_r == pfb_pkg::ST_OUT);
  assign out_read_data = rd_r;

  pfb_frame_ram u_frame (
    .clk(clk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
    .raddr(fr_raddr), .rdata(fr_rdata)
  );
  pfb_image_ram u_image (
    .clk(clk), .we(im_we), .waddr(in_address[IA-1:0]), .wdata(in_data_byte),
    .raddr(im_raddr), .rdata(im_rdata)
  );
endmodule

### hdl/pfb_checker.sv
// pfb_checker: port-level checks for the blitter core, bound to the top
// depends on pfb_pkg and on page_framebuffer_blitter_core ports only
module pfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [2:0] in_command,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data
);
  // a read item makes the block busy on the next cycle
  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command == pfb_pkg::CMD_READ |=> in_stall)
    else $error("read item not followed by busy");
  // no new item is taken while a result waits
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data))
    else $error("stalled result changed");
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("not busy after reset");
endmodule

bind page_framebuffer_blitter_core pfb_checker u_pfb_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_command(in_command), .out_valid(out_valid), .out_stall(out_stall),
  .out_read_data(out_read_data)
);
